// ===== hw/rtl/fcs_pkg.sv =====
// Shared types, widths and codes of the feature column scaler.
package fcs_pkg;

  localparam int unsigned MaxSamples = 64;
  localparam int unsigned AddrW      = $clog2(MaxSamples);
  localparam int unsigned CountW     = $clog2(MaxSamples + 1);
  localparam int unsigned SampleW    = 16;
  localparam int unsigned SumW       = SampleW + CountW;
  localparam int unsigned SqAccW     = 2 * SampleW - 2 + CountW;
  localparam int unsigned NqW        = SqAccW + CountW;
  localparam int unsigned VarW       = NqW - 1;
  localparam int unsigned RadBits    = VarW + SampleW;
  localparam int unsigned RadW       = RadBits + (RadBits % 2);
  localparam int unsigned RootW      = RadW / 2;
  localparam int unsigned DenW       = RootW + 2;
  localparam int unsigned DevW       = SampleW + CountW + 1;
  localparam int unsigned DevMagW    = DevW - 1;
  localparam int unsigned QuoW       = 17;
  localparam int unsigned NumW       = DevMagW + 23;
  localparam int unsigned SqStepW    = $clog2(RootW);
  localparam int unsigned DivStepW   = $clog2(QuoW);

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusFlat    = 2'd1;
  localparam logic [1:0] StatusDropped = 2'd2;

  localparam logic ModeMinMax = 1'b0;
  localparam logic ModeZScore = 1'b1;

  typedef struct packed {
    logic signed [15:0] sample_value;
    logic               last_sample;
  } fcs_in_t;

  typedef struct packed {
    logic signed [15:0] scaled_value;
    logic               last_result;
    logic [1:0]         status;
  } fcs_out_t;

  typedef enum logic [3:0] {
    ST_COLLECT,
    ST_SQ_READ,
    ST_SQ_DRAIN,
    ST_VAR_MUL,
    ST_VAR_SUB,
    ST_SQRT,
    ST_RD,
    ST_LOAD,
    ST_DIV,
    ST_PUT
  } fcs_state_e;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_COLLECT,
    OP_SQ_READ,
    OP_VAR_MUL,
    OP_VAR_SUB,
    OP_SQRT_STEP,
    OP_EMIT_READ,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_PUT
  } fcs_op_e;

  typedef struct packed {
    fcs_op_e op;
  } fcs_cmd_t;

  typedef struct packed {
    logic mode;
    logic idx_end;
    logic sqrt_done;
    logic div_done;
    logic out_free;
  } fcs_sts_t;

endpackage

// ===== hw/rtl/feature_column_scaler.sv =====
// Top level of the feature column scaler: sequencer plus datapath.
// Samples are taken one per cycle while a batch is collected; the beat marked
// last closes the batch and starts emission, during which no sample is taken.
// Min-max mode emits each result through one store read, a divider load, 17
// restoring divider steps and the output beat. Z-score mode first runs the
// sum-of-squares pass and variance, then the bitwise square root, before
// the same per-result emission. The divider takes one quotient bit per cycle;
// the next sample's emission starts only after the output beat. The mode
// register is sampled on the last beat of the batch.
module feature_column_scaler (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fcs_pkg::fcs_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fcs_pkg::fcs_out_t out_data_o
);

  fcs_pkg::fcs_cmd_t cmd;
  fcs_pkg::fcs_sts_t sts;

  fcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_last_i  (in_data_i.last_sample),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fcs_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

endmodule

// ===== hw/rtl/fcs_ram.sv =====
// Generic single write port RAM with one registered read port.
module fcs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/fcs_ctrl.sv =====
// Sequencer that steps the datapath through collection, variance, root and emission.
module fcs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_last_i,
  input  fcs_pkg::fcs_sts_t sts_i,
  output fcs_pkg::fcs_cmd_t cmd_o
);

  fcs_pkg::fcs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcs_pkg::ST_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o.op   = fcs_pkg::OP_IDLE;
    unique case (state_q)
      fcs_pkg::ST_COLLECT: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = fcs_pkg::OP_COLLECT;
          if (in_last_i) begin
            state_d = (sts_i.mode == fcs_pkg::ModeZScore) ? fcs_pkg::ST_SQ_READ
                                                           : fcs_pkg::ST_RD;
          end
        end
      end
      fcs_pkg::ST_SQ_READ: begin
        cmd_o.op = fcs_pkg::OP_SQ_READ;
        if (sts_i.idx_end) begin
          state_d = fcs_pkg::ST_SQ_DRAIN;
        end
      end
      fcs_pkg::ST_SQ_DRAIN: begin
        state_d = fcs_pkg::ST_VAR_MUL;
      end
      fcs_pkg::ST_VAR_MUL: begin
        cmd_o.op = fcs_pkg::OP_VAR_MUL;
        state_d  = fcs_pkg::ST_VAR_SUB;
      end
      fcs_pkg::ST_VAR_SUB: begin
        cmd_o.op = fcs_pkg::OP_VAR_SUB;
        state_d  = fcs_pkg::ST_SQRT;
      end
      fcs_pkg::ST_SQRT: begin
        cmd_o.op = fcs_pkg::OP_SQRT_STEP;
        if (sts_i.sqrt_done) begin
          state_d = fcs_pkg::ST_RD;
        end
      end
      fcs_pkg::ST_RD: begin
        cmd_o.op = fcs_pkg::OP_EMIT_READ;
        state_d  = fcs_pkg::ST_LOAD;
      end
      fcs_pkg::ST_LOAD: begin
        cmd_o.op = fcs_pkg::OP_DIV_LOAD;
        state_d  = fcs_pkg::ST_DIV;
      end
      fcs_pkg::ST_DIV: begin
        cmd_o.op = fcs_pkg::OP_DIV_STEP;
        if (sts_i.div_done) begin
          state_d = fcs_pkg::ST_PUT;
        end
      end
      fcs_pkg::ST_PUT: begin
        if (sts_i.out_free) begin
          cmd_o.op = fcs_pkg::OP_PUT;
          state_d  = sts_i.idx_end ? fcs_pkg::ST_COLLECT : fcs_pkg::ST_RD;
        end
      end
      default: begin
        state_d = fcs_pkg::ST_COLLECT;
      end
    endcase
  end

endmodule

// ===== hw/rtl/fcs_datapath.sv =====
// Sample store, running statistics, square root and divider of the scaler.
module fcs_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  fcs_pkg::fcs_in_t  in_data_i,
  input  fcs_pkg::fcs_cmd_t cmd_i,
  output fcs_pkg::fcs_sts_t sts_o,
  output fcs_pkg::fcs_out_t out_data_o,
  output logic              out_valid_o,
  input  logic              out_ready_i
);

  localparam int unsigned SW = fcs_pkg::SampleW;
  localparam int unsigned RW = fcs_pkg::RootW;
  localparam int unsigned DW = fcs_pkg::DenW;
  localparam int unsigned QW = fcs_pkg::QuoW;
  localparam int unsigned NW = fcs_pkg::NumW;

  // Batch statistics.
  logic                             mode_q, bmode_q;
  logic [fcs_pkg::CountW-1:0]       count_q;
  logic signed [SW-1:0]             min_q, max_q;
  logic signed [fcs_pkg::SumW-1:0]  sum_q;
  logic                             ovf_q;
  logic [fcs_pkg::AddrW-1:0]        idx_q;

  // Variance and root.
  logic [fcs_pkg::SqAccW-1:0]       sqacc_q;
  logic                             sq_vld_q;
  logic [fcs_pkg::NqW-1:0]          nq_q, ss_q;
  logic [fcs_pkg::RadW-1:0]         rad_q;
  logic [RW+1:0]                    srem_q;
  logic [RW-1:0]                    root_q;
  logic [fcs_pkg::SqStepW-1:0]      sstep_q;

  // Divider.
  logic [DW-1:0]                    den_q, drem_q;
  logic [QW-1:0]                    numlo_q, quo_q;
  logic                             sat_q, neg_q;
  logic [fcs_pkg::DivStepW-1:0]     dstep_q;

  fcs_pkg::fcs_out_t                out_q;
  logic                             out_valid_q;

  logic                             accept, room, ram_we;
  logic signed [SW-1:0]             x, rdata;
  logic [SW-1:0]                    rdata_raw;
  logic signed [2*SW-1:0]           sq;
  logic [fcs_pkg::NqW-1:0]          nq_d, var_d;
  logic signed [2*fcs_pkg::SumW-1:0] ss_full;
  logic [RW+3:0]                    srem2, strial;
  logic signed [SW:0]               a17, d17;
  logic signed [fcs_pkg::DevW-1:0]  dev;
  logic [fcs_pkg::DevMagW-1:0]      mag;
  logic [NW-1:0]                    num;
  logic [DW-1:0]                    den;
  logic [DW:0]                      drem2;
  logic                             flat, is_put, idx_end;
  logic signed [SW-1:0]             qval;
  logic [1:0]                       st;

  function automatic logic [RW+1:0] srem_q_sub(input logic [RW+3:0] p, input logic [RW+3:0] t);
    logic [RW+3:0] r;
    r = p - t;
    return r[RW+1:0];
  endfunction

  function automatic logic [DW-1:0] drem_sub(input logic [DW:0] p, input logic [DW-1:0] d);
    logic [DW:0] r;
    r = p - {1'b0, d};
    return r[DW-1:0];
  endfunction

  assign x       = in_data_i.sample_value;
  assign accept  = (cmd_i.op == fcs_pkg::OP_COLLECT);
  assign room    = (count_q < fcs_pkg::CountW'(fcs_pkg::MaxSamples));
  assign ram_we  = accept && room;
  assign rdata   = $signed(rdata_raw);
  assign idx_end = (fcs_pkg::CountW'(idx_q) == count_q - fcs_pkg::CountW'(1));
  assign flat    = (max_q == min_q);
  assign is_put  = (cmd_i.op == fcs_pkg::OP_PUT);

  fcs_ram #(
    .Width (SW),
    .Depth (fcs_pkg::MaxSamples)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[fcs_pkg::AddrW-1:0]),
    .wdata_i (x),
    .raddr_i (idx_q),
    .rdata_o (rdata_raw)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= fcs_pkg::ModeMinMax;
      count_q <= '0;
      min_q   <= 16'sh7fff;
      max_q   <= 16'sh8000;
      sum_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (ram_we) begin
        count_q <= count_q + fcs_pkg::CountW'(1);
        if (x < min_q) min_q <= x;
        if (x > max_q) max_q <= x;
        sum_q <= sum_q + fcs_pkg::SumW'(x);
      end else if (accept) begin
        ovf_q <= 1'b1;
      end
      // The batch returns to its empty state with the final result beat.
      if (is_put && idx_end) begin
        count_q <= '0;
        min_q   <= 16'sh7fff;
        max_q   <= 16'sh8000;
        sum_q   <= '0;
        ovf_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      sq_vld_q <= 1'b0;
    end else begin
      sq_vld_q <= (cmd_i.op == fcs_pkg::OP_SQ_READ);
      unique case (cmd_i.op)
        fcs_pkg::OP_COLLECT, fcs_pkg::OP_VAR_SUB: idx_q <= '0;
        fcs_pkg::OP_SQ_READ:                      idx_q <= idx_q + 1'b1;
        fcs_pkg::OP_PUT:                          idx_q <= idx_end ? '0 : idx_q + 1'b1;
        default:                                  idx_q <= idx_q;
      endcase
    end
  end

  // Sum of squares, variance numerator and bitwise square root.
  assign sq      = rdata * rdata;
  assign nq_d    = sqacc_q * count_q;
  assign ss_full = sum_q * sum_q;
  assign var_d   = nq_q - ss_q;
  assign srem2   = {srem_q, rad_q[fcs_pkg::RadW-1 -: 2]};
  assign strial  = (RW+4)'({root_q, 2'b01});

  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.last_sample) begin
      bmode_q <= mode_q;
      sqacc_q <= '0;
    end else if (sq_vld_q) begin
      sqacc_q <= sqacc_q + fcs_pkg::SqAccW'($unsigned(sq));
    end
    if (cmd_i.op == fcs_pkg::OP_VAR_MUL) begin
      nq_q <= nq_d;
      ss_q <= ss_full[fcs_pkg::NqW-1:0];
    end
    if (cmd_i.op == fcs_pkg::OP_VAR_SUB) begin
      rad_q   <= fcs_pkg::RadW'({var_d[fcs_pkg::VarW-1:0], {SW{1'b0}}});
      srem_q  <= '0;
      root_q  <= '0;
      sstep_q <= '0;
    end else if (cmd_i.op == fcs_pkg::OP_SQRT_STEP) begin
      rad_q   <= rad_q << 2;
      sstep_q <= sstep_q + 1'b1;
      if (srem2 >= strial) begin
        srem_q <= srem_q_sub(srem2, strial);
        root_q <= {root_q[RW-2:0], 1'b1};
      end else begin
        srem_q <= srem2[RW+1:0];
        root_q <= {root_q[RW-2:0], 1'b0};
      end
    end
  end

  // Divider operands: min-max takes (x-min)*8192+d over 2d, z-score takes
  // 2*|n*x-S|*2^20+s over 2s. The quotient is kept to 17 bits and anything
  // larger is flagged as saturated.
  always_comb begin
    a17 = (SW+1)'(rdata) - (SW+1)'(min_q);
    d17 = (SW+1)'(max_q) - (SW+1)'(min_q);
    dev = $signed({1'b0, count_q}) * rdata - sum_q;
    mag = dev[fcs_pkg::DevW-1] ? fcs_pkg::DevMagW'(-dev) : fcs_pkg::DevMagW'(dev);
    if (bmode_q == fcs_pkg::ModeZScore) begin
      num = (NW'(mag) << 21) + NW'(root_q);
      den = DW'({root_q, 1'b0});
    end else begin
      num = (NW'(a17[SW-1:0]) << 13) + NW'(d17[SW-1:0]);
      den = DW'({d17[SW-1:0], 1'b0});
    end
  end

  assign drem2 = {drem_q, numlo_q[QW-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == fcs_pkg::OP_DIV_LOAD) begin
      den_q   <= den;
      sat_q   <= (num[NW-1:QW] >= den);
      drem_q  <= DW'(num[NW-1:QW]);
      numlo_q <= num[QW-1:0];
      neg_q   <= dev[fcs_pkg::DevW-1];
      quo_q   <= '0;
      dstep_q <= '0;
    end else if (cmd_i.op == fcs_pkg::OP_DIV_STEP) begin
      numlo_q <= numlo_q << 1;
      dstep_q <= dstep_q + 1'b1;
      if (drem2 >= {1'b0, den_q}) begin
        drem_q <= drem_sub(drem2, den_q);
        quo_q  <= {quo_q[QW-2:0], 1'b1};
      end else begin
        drem_q <= drem2[DW-1:0];
        quo_q  <= {quo_q[QW-2:0], 1'b0};
      end
    end
  end

  // Final rounding limit and sign for the result beat.
  always_comb begin
    if (flat) begin
      qval = '0;
    end else if (bmode_q == fcs_pkg::ModeMinMax) begin
      qval = $signed(quo_q[SW-1:0]);
    end else if (!neg_q) begin
      qval = (sat_q || quo_q[QW-1] || quo_q[SW-1]) ? 16'sh7fff : $signed(quo_q[SW-1:0]);
    end else begin
      qval = (sat_q || quo_q[QW-1] || quo_q[SW-1]) ? 16'sh8000
                                                   : $signed(~quo_q[SW-1:0] + 1'b1);
    end
    st = flat ? fcs_pkg::StatusFlat : (ovf_q ? fcs_pkg::StatusDropped : fcs_pkg::StatusOk);
  end

  always_ff @(posedge clk_i) begin
    if (is_put) begin
      out_q.scaled_value <= qval;
      out_q.last_result  <= idx_end;
      out_q.status       <= st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (is_put) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

  assign sts_o.mode      = mode_q;
  assign sts_o.idx_end   = idx_end;
  assign sts_o.sqrt_done = (sstep_q == fcs_pkg::SqStepW'(RW - 1));
  assign sts_o.div_done  = (dstep_q == fcs_pkg::DivStepW'(QW - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// ===== hw/rtl/fcs_checker.sv =====
// Port-level checker for the feature column scaler and its bind.
module fcs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input fcs_pkg::fcs_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == fcs_pkg::StatusOk ||
                     out_data_o.status == fcs_pkg::StatusFlat ||
                     out_data_o.status == fcs_pkg::StatusDropped))
    else $error("invalid status code");

  a_flat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == fcs_pkg::StatusFlat
    |-> out_data_o.scaled_value == 16'sd0)
    else $error("zero spread result is not zero");

endmodule

bind feature_column_scaler fcs_checker u_fcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the feature column scaler.
`timescale 1ns / 100ps

module tb_top;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic              cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  fcs_pkg::fcs_in_t  in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  fcs_pkg::fcs_out_t out_data_o;

  feature_column_scaler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Tracks the open batch and computes the scaled column when it closes.
  class column_scoreboard;
    int                errors;
    int                results_seen;
    logic              mode;
    int                column[$];
    int                col_min;
    int                col_max;
    bit                dropped;
    fcs_pkg::fcs_out_t scaled_q[$];

    function new();
      errors = 0;
      results_seen = 0;
      mode = fcs_pkg::ModeMinMax;
      clear_column();
    endfunction

    function void clear_column();
      column.delete();
      col_min = 32767;
      col_max = -32768;
      dropped = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function void note_sample(fcs_pkg::fcs_in_t beat);
      int       x;
      int       n;
      longint   sum;
      longint   sumsq;
      longint   spread;
      longint   dev;
      longint   sr;
      longint unsigned root;
      longint unsigned mag;
      longint unsigned r;
      longint unsigned d;
      bit       flat;
      logic [1:0] st;
      int       q;
      fcs_pkg::fcs_out_t res;
      x = int'(beat.sample_value);
      if (column.size() < fcs_pkg::MaxSamples) begin
        column.insert(column.size(), x);
        if (x < col_min) col_min = x;
        if (x > col_max) col_max = x;
      end else begin
        dropped = 1;
      end
      if (!beat.last_sample) return;

      n = column.size();
      sum = 0;
      sumsq = 0;
      foreach (column[k]) begin
        sum += column[k];
        sumsq += longint'(column[k]) * column[k];
      end
      flat = (col_max == col_min);
      st = flat ? fcs_pkg::StatusFlat
                : (dropped ? fcs_pkg::StatusDropped : fcs_pkg::StatusOk);
      root = 0;
      if (mode == fcs_pkg::ModeZScore && !flat) begin
        spread = longint'(n) * sumsq - sum * sum;
        if (spread <= 0) flat = 1;
        else root = int_sqrt(longint'(spread) << 16);
        if (root == 0) flat = 1;
        if (flat) st = fcs_pkg::StatusFlat;
      end
      for (int k = 0; k < n; k++) begin
        q = 0;
        if (!flat) begin
          if (mode == fcs_pkg::ModeMinMax) begin
            d = col_max - col_min;
            q = int'(((longint'(column[k] - col_min)) * 8192 + d) / (2 * d));
          end else begin
            dev = longint'(n) * column[k] - sum;
            mag = (dev < 0 ? -dev : dev) << 20;
            r = (2 * mag + root) / (2 * root);
            sr = (r > 65536) ? 65536 : longint'(r);
            if (dev < 0) sr = -sr;
            q = (sr > 32767) ? 32767 : ((sr < -32768) ? -32768 : int'(sr));
          end
        end
        res.scaled_value = q[15:0];
        res.last_result = (k + 1 == n);
        res.status = st;
        scaled_q.insert(scaled_q.size(), res);
      end
      clear_column();
    endfunction

    task check_result(fcs_pkg::fcs_out_t got);
      fcs_pkg::fcs_out_t want;
      results_seen++;
      if (scaled_q.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      want = scaled_q.pop_front();
      if (got.scaled_value !== want.scaled_value)
        report($sformatf("scaled_value %0d, expected %0d",
                         got.scaled_value, want.scaled_value));
      if (got.last_result !== want.last_result)
        report($sformatf("last_result %0b, expected %0b",
                         got.last_result, want.last_result));
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
    endtask
  endclass

  column_scoreboard sb;
  int items_sent;
  int prev_value;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #2ms;
    $display("tb_top: errors");
    $finish;
  end

  // Results are checked on every beat the monitor sees.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  task automatic random_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return;
    else if (pick < 92) repeat ($urandom_range(1, 3)) @(negedge clk_i);
    else repeat ($urandom_range(10, 40)) @(negedge clk_i);
  endtask

  task automatic send_sample(int value, bit last);
    in_valid_i = 1'b1;
    in_data_i.sample_value = value[15:0];
    in_data_i.last_sample = last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(in_data_i);
    items_sent++;
    prev_value = value;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    random_gap();
  endtask

  task automatic set_mode(logic m);
    while (sb.scaled_q.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = m;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.mode = m;
  endtask

  function automatic int pick_value(int base);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return int'($signed(16'($urandom_range(0, 65535))));
    if (pick < 70) begin
      pick = base + $urandom_range(0, 600) - 300;
      return (pick > 32767) ? 32767 : ((pick < -32768) ? -32768 : pick);
    end
    if (pick < 90) begin
      case ($urandom_range(0, 3))
        0: return -32768;
        1: return 32767;
        2: return 0;
        default: return -1;
      endcase
    end
    return prev_value;
  endfunction

  task automatic send_batch(int len);
    int base;
    base = int'($signed(16'($urandom_range(0, 65535))));
    for (int k = 0; k < len; k++) send_sample(pick_value(base), k == len - 1);
  endtask

  // Receiver: random stalls, plus one long hold-off that backs up the block.
  initial begin
    bit held;
    int pick;
    held = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && sb.results_seen >= 30) begin
        held = 1;
        out_ready_i = 1'b0;
        for (int c = 0; c < 600; c++) @(negedge clk_i);
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        out_ready_i = 1'b1;
      end else if (pick < 95) begin
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(10, 40)) @(negedge clk_i);
      end
    end
  end

  initial begin
    int len;
    int pick;
    sb = new();
    items_sent = 0;
    prev_value = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: field extremes, a flat batch and a single sample in both modes.
    set_mode(fcs_pkg::ModeMinMax);
    for (int m = 0; m < 2; m++) begin
      if (m == 1) set_mode(fcs_pkg::ModeZScore);
      send_sample(-32768, 0);
      send_sample(32767, 0);
      send_sample(0, 0);
      send_sample(-1, 1);
      send_sample(256, 0);
      send_sample(256, 1);
      send_sample(-5, 1);
      send_sample(100, 0);
      send_sample(-100, 0);
      send_sample(37, 1);
    end

    // Random batches; now and then one that overruns the sample store.
    while (items_sent < 270) begin
      if ($urandom_range(0, 99) < 30) set_mode($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 83) len = $urandom_range(1, 10);
      else if (pick < 95) len = $urandom_range(11, 40);
      else len = $urandom_range(fcs_pkg::MaxSamples, fcs_pkg::MaxSamples + 8);
      send_batch(len);
    end

    while (sb.scaled_q.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
